[rtl/msa_pkg.sv]
package msa_pkg;

  localparam int NUM_CH     = 16;
  localparam int CH_W       = $clog2(NUM_CH);
  localparam int MASK_SLOTS = 128;
  localparam int SLOT_W     = $clog2(MASK_SLOTS);
  localparam int FIFO_DEPTH = 128;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = PTR_W + 1;
  localparam int FIFO_WORDS = NUM_CH * FIFO_DEPTH;
  localparam int FIFO_AW    = CH_W + PTR_W;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 16;

  typedef enum logic [0:0] {
    CFG_ENABLE       = 1'b0,
    CFG_CHAN_ENABLES = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SLOT_OVR = 3'd1,
    ST_FIFO_OVR = 3'd2,
    ST_FIFO_UDR = 3'd3,
    ST_CH_DIS   = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]  chan_id;
    logic [31:0] sample_value;
    logic        message_end;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  out_channel;
    logic [31:0] out_sample;
    status_t     status;
    logic        frame_last;
  } out_item_t;

endpackage

[rtl/msa_ram.sv]
module msa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/multichannel_sample_aligner_unit.sv]
// Multichannel sample aligner. Samples tagged with an acquisition channel are
// pushed into per-channel FIFOs; when every enabled channel has
// delivered sample number N, one sample per enabled channel is emitted in
// ascending channel order, tagged with its dense rank, frame_last on the
// final one. Errors (slot overrun, FIFO overrun, FIFO underrun, channel not
// enabled) give a single status beat and the rest of the message is dropped
// up to its message_end sample. An item is taken when start is high and busy
// is low. An item that completes no frame keeps busy high through S_EVAL,
// while the slot's arrival mask, read from memory, is checked and updated. An
// item that completes a frame adds a DRAIN and a POP state per enabled channel
// plus a DRAIN per disabled channel below the highest enabled one, set by the
// single read port of the sample memory. Result beats are one-cycle strobes
// on out_strobe, never two back to back; the receiver cannot stall,
// so capture every strobe. Writing either configuration register restarts
// acquisition: pointers, counters and arrival masks clear at once, with no
// clearing pass. Write configuration only while busy is low.
module multichannel_sample_aligner_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  msa_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output msa_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  msa_pkg::cfg_index_t cfg_index,
  input  logic [msa_pkg::CFG_W-1:0] cfg_wdata
);
  import msa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_POP   = 4'b1000
  } state_t;

  // Configuration
  logic              enable_r,  enable_nxt;
  logic [NUM_CH-1:0] mask_r,    mask_nxt;

  // Per-channel FIFO bookkeeping and arrival counters
  logic [PTR_W-1:0]  wp_r   [NUM_CH];
  logic [PTR_W-1:0]  wp_nxt [NUM_CH];
  logic [PTR_W-1:0]  rp_r   [NUM_CH];
  logic [PTR_W-1:0]  rp_nxt [NUM_CH];
  logic [FILL_W-1:0] fill_r   [NUM_CH];
  logic [FILL_W-1:0] fill_nxt [NUM_CH];
  logic [SLOT_W-1:0] cnt_r   [NUM_CH];
  logic [SLOT_W-1:0] cnt_nxt [NUM_CH];

  // One valid bit per arrival-mask slot: an invalid slot reads as zero
  logic [MASK_SLOTS-1:0] slot_valid_r, slot_valid_nxt;
  logic                  discarding_r, discarding_nxt;

  // Sequencer
  state_t            state_r, state_nxt;
  in_item_t          item_r,  item_nxt;
  logic [SLOT_W-1:0] slot_r,  slot_nxt;
  logic [CH_W-1:0]   idx_r,   idx_nxt;
  logic [CH_W-1:0]   rank_r,  rank_nxt;

  // Result register
  out_item_t out_r, out_nxt;
  logic      out_strobe_r, out_strobe_nxt;

  // Memory ports
  logic              mask_we;
  logic [NUM_CH-1:0] mask_wdata;
  logic [NUM_CH-1:0] mask_q;
  logic              fifo_we;
  logic [FIFO_AW-1:0] fifo_waddr;
  logic [FIFO_AW-1:0] fifo_raddr;
  logic [SAMPLE_W-1:0] fifo_q;

  // Working values
  logic [CH_W-1:0]   ch;
  logic [NUM_CH-1:0] ch_bit;
  logic [NUM_CH-1:0] cur_mask;
  logic [NUM_CH-1:0] new_mask;
  logic              drain_last;

  assign ch         = item_r.chan_id;
  assign ch_bit     = NUM_CH'(1) << ch;
  assign cur_mask   = slot_valid_r[slot_r] ? mask_q : '0;
  assign new_mask   = cur_mask | ch_bit;
  // No enabled channel above the current one: this pop closes the frame
  assign drain_last = ((mask_r >> idx_r) >> 1) == '0;
  assign fifo_waddr = {ch, wp_r[ch]};
  assign fifo_raddr = {idx_r, rp_r[idx_r]};
  assign mask_wdata = new_mask;

  msa_ram #(
    .WIDTH (NUM_CH),
    .DEPTH (MASK_SLOTS)
  ) u_mask_ram (
    .clk     (clk),
    .wr_en   (mask_we),
    .wr_addr (slot_r),
    .wr_data (mask_wdata),
    .rd_addr (cnt_r[in_item.chan_id]),
    .rd_data (mask_q)
  );

  msa_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (FIFO_WORDS)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (fifo_waddr),
    .wr_data (item_r.sample_value),
    .rd_addr (fifo_raddr),
    .rd_data (fifo_q)
  );

  always_comb begin
    enable_nxt     = enable_r;
    mask_nxt       = mask_r;
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    slot_valid_nxt = slot_valid_r;
    discarding_nxt = discarding_r;
    state_nxt      = state_r;
    item_nxt       = item_r;
    slot_nxt       = slot_r;
    idx_nxt        = idx_r;
    rank_nxt       = rank_r;
    out_nxt        = out_r;
    out_strobe_nxt = 1'b0;
    mask_we        = 1'b0;
    fifo_we        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          // Mask memory read for this channel's slot is issued this cycle
          item_nxt = in_item;
          slot_nxt = cnt_r[in_item.chan_id];
          if (enable_r) begin
            if (discarding_r) begin
              if (in_item.message_end) begin
                discarding_nxt = 1'b0;
              end
            end else begin
              state_nxt = S_EVAL;
            end
          end
        end
      end

      S_EVAL: begin
        out_nxt.out_channel = '0;
        out_nxt.out_sample  = '0;
        out_nxt.frame_last  = 1'b1;
        if (!mask_r[ch] || cur_mask[ch] || (fill_r[ch] >= FILL_W'(FIFO_DEPTH))) begin
          // Report the error, then drop the rest of the message
          priority if (!mask_r[ch]) begin
            out_nxt.status = ST_CH_DIS;
          end else if (cur_mask[ch]) begin
            out_nxt.status = ST_SLOT_OVR;
          end else begin
            out_nxt.status = ST_FIFO_OVR;
          end
          out_strobe_nxt = 1'b1;
          discarding_nxt = !item_r.message_end;
          state_nxt      = S_IDLE;
        end else begin
          // Push the sample and mark its arrival
          fifo_we              = 1'b1;
          wp_nxt[ch]           = wp_r[ch] + PTR_W'(1);
          fill_nxt[ch]         = fill_r[ch] + FILL_W'(1);
          cnt_nxt[ch]          = cnt_r[ch] + SLOT_W'(1);
          mask_we              = 1'b1;
          slot_valid_nxt[slot_r] = 1'b1;
          if (new_mask == mask_r) begin
            idx_nxt   = '0;
            rank_nxt  = '0;
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DRAIN: begin
        priority if (!mask_r[idx_r]) begin
          idx_nxt = idx_r + CH_W'(1);
        end else if (fill_r[idx_r] == '0) begin
          // Underrun: earlier beats stand, slot stays marked
          out_nxt.out_channel = rank_r;
          out_nxt.out_sample  = '0;
          out_nxt.status      = ST_FIFO_UDR;
          out_nxt.frame_last  = 1'b1;
          out_strobe_nxt      = 1'b1;
          discarding_nxt      = !item_r.message_end;
          state_nxt           = S_IDLE;
        end else begin
          // Read issued at the old read pointer; advance it
          rp_nxt[idx_r]   = rp_r[idx_r] + PTR_W'(1);
          fill_nxt[idx_r] = fill_r[idx_r] - FILL_W'(1);
          state_nxt       = S_POP;
        end
      end

      S_POP: begin
        out_nxt.out_channel = rank_r;
        out_nxt.out_sample  = fifo_q;
        out_nxt.status      = ST_OK;
        out_nxt.frame_last  = drain_last;
        out_strobe_nxt      = 1'b1;
        rank_nxt            = rank_r + CH_W'(1);
        if (drain_last) begin
          slot_valid_nxt[slot_r] = 1'b0;
          state_nxt              = S_IDLE;
        end else begin
          idx_nxt   = idx_r + CH_W'(1);
          state_nxt = S_DRAIN;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Any register write restarts acquisition
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:       enable_nxt = cfg_wdata[0];
        CFG_CHAN_ENABLES: mask_nxt   = cfg_wdata[NUM_CH-1:0];
        default:          enable_nxt = enable_r;
      endcase
      for (int i = 0; i < NUM_CH; i++) begin
        wp_nxt[i]   = '0;
        rp_nxt[i]   = '0;
        fill_nxt[i] = '0;
        cnt_nxt[i]  = '0;
      end
      slot_valid_nxt = '0;
      discarding_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      mask_r       <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        wp_r[i]   <= '0;
        rp_r[i]   <= '0;
        fill_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
      slot_valid_r <= '0;
      discarding_r <= 1'b0;
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      enable_r     <= enable_nxt;
      mask_r       <= mask_nxt;
      wp_r         <= wp_nxt;
      rp_r         <= rp_nxt;
      fill_r       <= fill_nxt;
      cnt_r        <= cnt_nxt;
      slot_valid_r <= slot_valid_nxt;
      discarding_r <= discarding_nxt;
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    slot_r <= slot_nxt;
    idx_r  <= idx_nxt;
    rank_r <= rank_nxt;
    out_r  <= out_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

`ifndef SYNTHESIS
  // Two beats never come back to back
  a_beat_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |=> !out_strobe_r)
    else $error("back-to-back result beats");

  // A beat only follows work in progress
  a_beat_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(busy))
    else $error("result beat without work");

  // The closing beat of an item leaves the sequencer idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_r.frame_last) |-> !busy)
    else $error("frame_last while still busy");

  // Error beats always close the item
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && (out_r.status != ST_OK)) |-> out_r.frame_last)
    else $error("error beat without frame_last");

  // Discarding starts only together with an error beat
  a_discard_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(discarding_r) |-> (out_strobe_r && (out_r.status != ST_OK)))
    else $error("discard without error beat");
`endif

endmodule
